// ===== rtl/acs_pkg.sv =====
// Shared constants for the cumulative sum core.
// Configuration register indexes and the fixed widths of the port fields.
// No dependencies.
package acs_pkg;

  localparam int VALUE_W      = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int INNER_SIZE_W = 11;
  localparam int AXIS_LEN_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXCLUSIVE  = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_AXIS_LEN   = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/acs_sum_ram.sv =====
// Running sum store: one entry per inner position.
// Synchronous memory with one write port and one registered read port.
// No dependencies.
module acs_sum_ram #(
  parameter int Depth  = 1024,
  parameter int Width  = 32,
  parameter int AddrW  = 10
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read-before-write: a read of the entry written at the same edge sees the old value.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/axis_cumulative_sum_core.sv =====
// Items pass the second stage and output register to m_axis_tvalid, one per cycle
// unless the output stalls. The sum memory, one access per port per cycle, is read
// on acceptance and written back as items leave the second stage; overlaps forward.
// Reset clears the handshake state, the position counters and the registers to
// exclusive off, inner size 1, axis length 1; the sum memory is not cleared.
// Top level: depends on acs_pkg and acs_sum_ram.
module axis_cumulative_sum_core #(
  parameter int INNER_MAX  = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [acs_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [acs_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // Input stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic signed [acs_pkg::VALUE_W-1:0]     s_axis_tdata,  // [31:0] in_value
  input  logic                                   s_axis_tuser,  // [0] restart
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic signed [acs_pkg::VALUE_W-1:0]     m_axis_tdata   // [31:0] out_value
);
  import acs_pkg::*;

  localparam int IW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int CW = (IW + 1 > INNER_SIZE_W) ? IW + 1 : INNER_SIZE_W;
  localparam int AW = AXIS_LEN_W + 1;

  // Configuration registers.
  logic                    excl_q;
  logic [INNER_SIZE_W-1:0] inner_size_q;
  logic [AXIS_LEN_W-1:0]   axis_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      excl_q       <= 1'b0;
      inner_size_q <= INNER_SIZE_W'(1);
      axis_len_q   <= AXIS_LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXCLUSIVE:  excl_q       <= cfg_data_i[0];
        CFG_INNER_SIZE: inner_size_q <= cfg_data_i[INNER_SIZE_W-1:0];
        CFG_AXIS_LEN:   axis_len_q   <= cfg_data_i[AXIS_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective bounds: zero counts as one, inner size saturates at the store depth.
  logic [CW-1:0] inner_ext;
  logic [CW-1:0] eff_inner;
  logic [AW-1:0] eff_axis;

  always_comb begin
    inner_ext = CW'(inner_size_q);
    if (inner_ext == '0) begin
      eff_inner = CW'(1);
    end else if (inner_ext > CW'(INNER_MAX)) begin
      eff_inner = CW'(INNER_MAX);
    end else begin
      eff_inner = inner_ext;
    end
    eff_axis = (axis_len_q == '0) ? AW'(1) : AW'(axis_len_q);
  end

  // Handshake and pipeline control.
  logic                   s1_valid_q;
  logic                   out_valid_q;
  logic                   s1_adv;
  logic                   in_acc;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Position counters.
  logic [IW-1:0]         inner_pos_q, inner_pos_d;
  logic [AXIS_LEN_W-1:0] axis_pos_q, axis_pos_d;
  logic [IW-1:0]         cur_inner;
  logic [AXIS_LEN_W-1:0] cur_axis;
  logic [CW-1:0]         inner_inc;
  logic [AW-1:0]         axis_inc;

  always_comb begin
    cur_inner   = s_axis_tuser ? '0 : inner_pos_q;
    cur_axis    = s_axis_tuser ? '0 : axis_pos_q;
    inner_inc   = CW'(cur_inner) + CW'(1);
    axis_inc    = AW'(cur_axis) + AW'(1);
    inner_pos_d = inner_pos_q;
    axis_pos_d  = axis_pos_q;
    if (in_acc) begin
      if (inner_inc >= eff_inner) begin
        inner_pos_d = '0;
        axis_pos_d  = (axis_inc >= eff_axis) ? '0 : axis_inc[AXIS_LEN_W-1:0];
      end else begin
        inner_pos_d = inner_inc[IW-1:0];
        axis_pos_d  = cur_axis;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_pos_q <= '0;
      axis_pos_q  <= '0;
    end else begin
      inner_pos_q <= inner_pos_d;
      axis_pos_q  <= axis_pos_d;
    end
  end

  // Second stage: the read data arrives and the sum is formed.
  logic [DATA_WIDTH-1:0] s1_x_q;
  logic [IW-1:0]         s1_slot_q;
  logic                  s1_first_q;
  logic                  fwd_q;
  logic [DATA_WIDTH-1:0] fwd_data_q;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] prev;
  logic [DATA_WIDTH-1:0] sum;
  logic signed [DATA_WIDTH-1:0] res;

  always_comb begin
    prev = fwd_q ? fwd_data_q : rd_data;
    sum  = s1_first_q ? s1_x_q : prev + s1_x_q;
    if (excl_q) begin
      res = s1_first_q ? '0 : prev;
    end else begin
      res = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q     <= DATA_WIDTH'(s_axis_tdata);
      s1_slot_q  <= cur_inner;
      s1_first_q <= (cur_axis == '0);
      // The entry written back at this edge is not yet visible to the read.
      fwd_q      <= s1_adv && (s1_slot_q == cur_inner);
      fwd_data_q <= sum;
    end
  end

  acs_sum_ram #(
    .Depth (INNER_MAX),
    .Width (DATA_WIDTH),
    .AddrW (IW)
  ) u_sum_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (cur_inner),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_slot_q),
    .wr_data_i (sum)
  );

  // Output register.
  logic signed [VALUE_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= VALUE_W'(res);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/acs_checker.sv =====
// Port-level checks for the cumulative sum core, attached by a bind.
// Depends on acs_pkg and the top level axis_cumulative_sum_core.
module acs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [acs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input logic [acs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic signed [acs_pkg::VALUE_W-1:0]  s_axis_tdata,
  input logic                                s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic signed [acs_pkg::VALUE_W-1:0]  m_axis_tdata
);
  import acs_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A held result keeps its valid.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A held result keeps its data.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The input side only stalls when a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // An accepted item reaches the output if the output drains while it is in stage two.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after accepted item");

endmodule

bind axis_cumulative_sum_core acs_checker u_acs_checker (.*);

// ===== tb/axis_cumulative_sum_core_tb.sv =====
// Self-checking testbench for axis_cumulative_sum_core: directed and random
// tensor streams under several register settings and back-pressure patterns.
// Depends on acs_pkg and the RTL of the core; needs no files or arguments.
`timescale 1ns / 1ps

module axis_cumulative_sum_core_tb;
  import acs_pkg::*;

  localparam int INNER_MAX = 1024;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               restart;
    logic [VALUE_W-1:0] sum;
  } elem_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic signed [VALUE_W-1:0] s_axis_tdata = '0;  // [31:0] in_value
  logic s_axis_tuser = 1'b0;                     // [0] restart
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic signed [VALUE_W-1:0] m_axis_tdata;       // [31:0] out_value

  axis_cumulative_sum_core #(
    .INNER_MAX (INNER_MAX),
    .DATA_WIDTH(VALUE_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the core: registers, per-column sums and the two position counters.
  logic                  excl_q = 1'b0;
  logic [INNER_SIZE_W-1:0] inner_size_q = INNER_SIZE_W'(1);
  logic [AXIS_LEN_W-1:0] axis_len_q = AXIS_LEN_W'(1);
  logic [VALUE_W-1:0]    col_sum [INNER_MAX];
  bit                    col_written [INNER_MAX];
  logic [9:0]            inner_pos = '0;
  logic [15:0]           axis_pos = '0;

  elem_t              elem_pending_q[$];
  logic [VALUE_W-1:0] sum_expected_q[$];
  elem_t              in_flight;
  logic [VALUE_W-1:0] want_sum;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 fail_count = 0;

  // Works out the output for one element and advances the shadow state.
  function automatic logic [VALUE_W-1:0] cumsum_step(logic [VALUE_W-1:0] x, logic restart);
    int eff_inner;
    int eff_axis;
    logic [VALUE_W-1:0] prev;
    logic [VALUE_W-1:0] acc;
    logic [VALUE_W-1:0] res;
    eff_inner = (inner_size_q == 0) ? 1 :
                (inner_size_q > INNER_MAX) ? INNER_MAX : int'(inner_size_q);
    eff_axis = (axis_len_q == 0) ? 1 : int'(axis_len_q);
    if (restart) begin
      inner_pos = '0;
      axis_pos = '0;
    end
    if (axis_pos == 0) begin
      acc = x;
      res = excl_q ? '0 : x;
    end else begin
      prev = col_sum[inner_pos];
      acc = prev + x;
      res = excl_q ? prev : acc;
    end
    col_sum[inner_pos] = acc;
    col_written[inner_pos] = 1'b1;
    if (int'(inner_pos) + 1 >= eff_inner) begin
      inner_pos = '0;
      if (int'(axis_pos) + 1 >= eff_axis) axis_pos = '0;
      else axis_pos = axis_pos + 1'b1;
    end else begin
      inner_pos = inner_pos + 1'b1;
    end
    return res;
  endfunction

  // A read of a column sum that was never written is not allowed, so such an
  // element is turned into the first element of a new tensor instead.
  task automatic queue_elem(logic [VALUE_W-1:0] x, logic restart);
    elem_t e;
    if (!restart && axis_pos != 0 && !col_written[inner_pos]) restart = 1'b1;
    e.value = x;
    e.restart = restart;
    e.sum = cumsum_step(x, restart);
    elem_pending_q.push_back(e);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_EXCLUSIVE:  excl_q = val[0];
      CFG_INNER_SIZE: inner_size_q = val[INNER_SIZE_W-1:0];
      CFG_AXIS_LEN:   axis_len_q = val[AXIS_LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (elem_pending_q.size() != 0 || s_axis_tvalid || sum_expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return '0;
      4: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed tensors: restart only at a tensor boundary, plus a little noise.
  task automatic run_random(logic excl, int inner, int axis, int count, int idle, int stall);
    logic restart;
    wait_idle();
    write_reg(CFG_EXCLUSIVE, CFG_DATA_W'(excl));
    write_reg(CFG_INNER_SIZE, CFG_DATA_W'(inner));
    write_reg(CFG_AXIS_LEN, CFG_DATA_W'(axis));
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (inner_pos == 0 && axis_pos == 0) restart = 1'($urandom_range(1));
      else restart = ($urandom_range(99) < 3);
      queue_elem(rand_value(), restart);
      // Half way through, hold the stream back until the core has drained.
      if (i == count / 2) wait_idle();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) sum_expected_q.push_back(in_flight.sum);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (elem_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_flight = elem_pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= in_flight.value;
          s_axis_tuser <= in_flight.restart;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sum_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected item, out_value %h", $realtime, m_axis_tdata);
        end else begin
          want_sum = sum_expected_q.pop_front();
          if (m_axis_tdata !== want_sum) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: out_value expected %h, got %h", $realtime, want_sum,
                       m_axis_tdata);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: every element is its own sum.
    queue_elem('0, 1'b1);
    queue_elem(32'h7FFF_FFFF, 1'b0);
    queue_elem(32'h8000_0000, 1'b1);
    queue_elem(32'hFFFF_FFFF, 1'b0);
    queue_elem(32'h0000_0001, 1'b0);

    // Exclusive sums across two columns, with wrap-around at the top.
    wait_idle();
    write_reg(CFG_EXCLUSIVE, 16'd1);
    write_reg(CFG_INNER_SIZE, 16'd2);
    write_reg(CFG_AXIS_LEN, 16'd3);
    queue_elem(32'h7FFF_FFFF, 1'b1);
    queue_elem(32'h0000_0001, 1'b0);
    queue_elem(32'h0000_0001, 1'b0);
    queue_elem(32'h0000_0001, 1'b0);
    queue_elem(32'h8000_0000, 1'b0);
    queue_elem(32'h0000_0005, 1'b0);

    wait_idle();
    write_reg(CFG_EXCLUSIVE, 16'd0);
    queue_elem(32'h7FFF_FFFF, 1'b1);
    queue_elem(32'hFFFF_FFFF, 1'b0);
    queue_elem(32'h0000_0001, 1'b0);
    queue_elem(32'h0000_0001, 1'b0);
    queue_elem(32'hFFFF_FFFF, 1'b0);

    // Zero sizes behave as one; a write to the spare index is ignored.
    wait_idle();
    write_reg(CFG_INNER_SIZE, 16'd0);
    write_reg(CFG_AXIS_LEN, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    queue_elem(32'h1234_5678, 1'b0);
    queue_elem(32'hDEAD_BEEF, 1'b0);
    queue_elem(32'h0000_0003, 1'b1);

    // An oversized inner size saturates at the column count.
    wait_idle();
    write_reg(CFG_INNER_SIZE, 16'd2047);
    write_reg(CFG_AXIS_LEN, 16'd2);
    queue_elem(32'h0000_0010, 1'b1);
    queue_elem(32'h0000_0020, 1'b0);
    queue_elem(32'h0000_0030, 1'b0);

    // Shrinking the inner size leaves the counter past its bound; it wraps next.
    wait_idle();
    write_reg(CFG_INNER_SIZE, 16'd2);
    queue_elem(32'h0000_0040, 1'b0);
    queue_elem(32'h0000_0050, 1'b0);
    queue_elem(32'hFFFF_FFF0, 1'b0);

    run_random(1'b0, 3, 5, 150, 0, 0);
    run_random(1'b1, 1, 65535, 120, 71, 0);
    run_random(1'b0, 16, 4, 150, 0, 71);
    run_random(1'b1, 7, 1, 100, 31, 31);
    run_random(1'b0, 1024, 65535, 150, 31, 31);
    run_random(1'b1, 700, 2, 760, 31, 31);
    run_random(1'b0, 0, 0, 80, 0, 0);
    run_random(1'b1, 5, 3, 60, 0, 71);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && sum_expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/acs_pkg.sv
rtl/acs_sum_ram.sv
rtl/axis_cumulative_sum_core.sv
rtl/acs_checker.sv
tb/axis_cumulative_sum_core_tb.sv
